FILE: sv/x86pd_pkg.sv
package x86pd_pkg;

	localparam int ADDR_W = 32;
	localparam int MAXPEND = 9;
	localparam logic [31:0] ADDR_MASK = (ADDR_W >= 32) ? 32'hffff_ffff :
		32'((64'd1 << ADDR_W) - 64'd1);

	localparam logic [0:0] CFG_ARCH_MODE = 1'd0;
	localparam logic [0:0] CFG_START_ADDRESS = 1'd1;

	localparam logic [1:0] MODE_NONX86 = 2'd0;
	localparam logic [1:0] MODE_X86_32 = 2'd1;
	localparam logic [1:0] MODE_X86_64 = 2'd2;

	localparam logic [7:0] OP_NOP = 8'h90;
	localparam logic [7:0] OP_RET = 8'hc3;
	localparam logic [7:0] OP_RETIMM = 8'hc2;
	localparam logic [7:0] OP_CALL = 8'he8;
	localparam logic [7:0] OP_JMP32 = 8'he9;
	localparam logic [7:0] OP_JMP8 = 8'heb;
	localparam logic [7:0] OP_ESC = 8'h0f;
	localparam logic [7:0] OP_GRP5 = 8'hff;
	localparam logic [7:0] OP_PUSH_LO = 8'h50;
	localparam logic [7:0] OP_POP_HI = 8'h5f;
	localparam logic [7:0] OP_JCC_LO = 8'h70;
	localparam logic [7:0] OP_MOV_LO = 8'hb8;

	localparam logic [3:0] CL_NOP = 4'd0;
	localparam logic [3:0] CL_PUSH = 4'd1;
	localparam logic [3:0] CL_POP = 4'd2;
	localparam logic [3:0] CL_RET = 4'd3;
	localparam logic [3:0] CL_RETIMM = 4'd4;
	localparam logic [3:0] CL_CALLREL = 4'd5;
	localparam logic [3:0] CL_JMP32 = 4'd6;
	localparam logic [3:0] CL_JMP8 = 4'd7;
	localparam logic [3:0] CL_JCC8 = 4'd8;
	localparam logic [3:0] CL_JCC32 = 4'd9;
	localparam logic [3:0] CL_CALLIND = 4'd10;
	localparam logic [3:0] CL_JMPIND = 4'd11;
	localparam logic [3:0] CL_FFOTHER = 4'd12;
	localparam logic [3:0] CL_MOV = 4'd13;
	localparam logic [3:0] CL_DBUNK = 4'd14;
	localparam logic [3:0] CL_DBTRUNC = 4'd15;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       region_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        inst_address;
		logic [3:0]         inst_length;
		logic [3:0]         inst_class;
		logic [2:0]         reg_index;
		logic               operand_is_memory;
		logic [7:0]         modrm_value;
		logic [7:0]         sib_value;
		logic signed [31:0] displacement;
		logic [31:0]        branch_target;
		logic [63:0]        imm_value;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		logic append;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic can_emit;
	} dp_stat_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DEC  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

endpackage

FILE: sv/x86_subset_instruction_predecoder.sv
// predecoder for a small x86 subset: code bytes in, one record per instruction out
// in channel: in_valid/in_ready with in_item {code_byte, region_end}; region_end
// marks the last byte of a region, after which held bytes are flushed as records
// out channel: out_valid/out_ready with out_item, one record per instruction;
// last_of_run flags the final record of a region
// config: cfg_we/cfg_index/cfg_data, index 0 arch_mode, 1 start_address; write
// only while idle. start_address applies from the next region
// sequence: a byte is taken in the idle state, then a decode state follows; each
// record then sits in the output register until taken, and after the handoff
// the decode state runs again; a new byte is taken only when no record can be
// emitted. the single decode/queue controller sets this order. receiver
// stall: the record holds in the output register and no new byte is taken
// until it is accepted
// reset: arst_n clears the byte queue, leaves no region open, arch_mode is
// x86 32-bit and start_address zero
module x86_subset_instruction_predecoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  x86pd_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output x86pd_pkg::out_item_t out_item
);

	x86pd_pkg::dp_cmd_t  cmd;
	x86pd_pkg::dp_stat_t stat;

	x86pd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	x86pd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item)
	);

endmodule

FILE: sv/x86pd_ctrl.sv
module x86pd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  x86pd_pkg::dp_stat_t stat,
	output x86pd_pkg::dp_cmd_t  cmd
);

	x86pd_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			x86pd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.append = 1'b1;
					state_d = x86pd_pkg::S_DEC;
				end
			end
			x86pd_pkg::S_DEC: begin
				if (stat.can_emit) begin
					cmd.emit = 1'b1;
					state_d = x86pd_pkg::S_OUT;
				end else begin
					state_d = x86pd_pkg::S_IDLE;
				end
			end
			x86pd_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = x86pd_pkg::S_DEC;
			end
			default: state_d = x86pd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= x86pd_pkg::S_IDLE;
		else state_q <= state_d;
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while record pending");

	a_emit_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid) else $error("record loaded but not offered");

endmodule

FILE: sv/x86pd_dp.sv
module x86pd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  x86pd_pkg::in_item_t  in_item,
	input  x86pd_pkg::dp_cmd_t   cmd,
	output x86pd_pkg::dp_stat_t  stat,
	output x86pd_pkg::out_item_t out_item
);

	logic [1:0]  mode_q;
	logic [31:0] start_q;
	logic [7:0]  pend_q [x86pd_pkg::MAXPEND];
	logic [3:0]  cnt_q;
	logic [31:0] addr_q;
	logic        in_region_q;
	logic        end_q;
	x86pd_pkg::out_item_t out_q;

	x86pd_pkg::out_item_t rec;
	logic        wait_more;

	// head-of-queue decode
	always_comb begin
		logic [7:0]  op, m;
		logic [1:0]  md;
		logic [2:0]  rm, rg;
		logic [3:0]  need, want, dw, c_cls;
		logic        dpos3, rel8, relpos2;
		logic [31:0] rel;
		op = pend_q[0];
		m = pend_q[1];
		md = m[7:6];
		rm = m[2:0];
		rg = m[5:3];
		need = 4'd2;
		want = 4'd0;
		dw = 4'd0;
		c_cls = x86pd_pkg::CL_DBUNK;
		dpos3 = 1'b0;
		rel8 = 1'b0;
		relpos2 = 1'b0;
		rel = '0;
		wait_more = 1'b0;
		rec = '0;
		rec.inst_address = addr_q;
		rec.inst_length = 4'd1;
		rec.inst_class = x86pd_pkg::CL_DBUNK;
		if (mode_q == x86pd_pkg::MODE_NONX86) begin
			rec.inst_class = x86pd_pkg::CL_DBUNK;
		end else if (op == x86pd_pkg::OP_NOP) begin
			rec.inst_class = x86pd_pkg::CL_NOP;
		end else if (op >= x86pd_pkg::OP_PUSH_LO && op <= x86pd_pkg::OP_POP_HI) begin
			rec.inst_class = op[3] ? x86pd_pkg::CL_POP : x86pd_pkg::CL_PUSH;
			rec.reg_index = op[2:0];
		end else if (op == x86pd_pkg::OP_RET) begin
			rec.inst_class = x86pd_pkg::CL_RET;
		end else if (op == x86pd_pkg::OP_GRP5) begin
			if (cnt_q < 4'd2) begin
				if (!end_q) wait_more = 1'b1;
			end else begin
				if (md == 2'd3) begin
					need = 4'd2;
				end else if (rm == 3'd4) begin
					dpos3 = 1'b1;
					if (cnt_q < 4'd3) begin
						need = 4'd3;
					end else begin
						if (md == 2'd0 && pend_q[2][2:0] == 3'd5) dw = 4'd4;
						else if (md == 2'd1) dw = 4'd1;
						else if (md == 2'd2) dw = 4'd4;
						need = 4'd3 + dw;
					end
				end else begin
					if (md == 2'd0 && rm == 3'd5) dw = 4'd4;
					else if (md == 2'd1) dw = 4'd1;
					else if (md == 2'd2) dw = 4'd4;
					need = 4'd2 + dw;
				end
				if (cnt_q < need) begin
					if (!end_q) wait_more = 1'b1;
					else rec.inst_class = x86pd_pkg::CL_DBTRUNC;
				end else begin
					rec.inst_class = (rg == 3'd2) ? x86pd_pkg::CL_CALLIND :
						((rg == 3'd4) ? x86pd_pkg::CL_JMPIND : x86pd_pkg::CL_FFOTHER);
					rec.inst_length = need;
					rec.operand_is_memory = (md != 2'd3);
					rec.modrm_value = m;
					if (md != 2'd3 && rm == 3'd4) rec.sib_value = pend_q[2];
					if (dw == 4'd1) begin
						rec.displacement = dpos3 ? 32'(signed'(pend_q[3])) :
							32'(signed'(pend_q[2]));
					end else if (dw == 4'd4) begin
						rec.displacement = dpos3 ?
							{pend_q[6], pend_q[5], pend_q[4], pend_q[3]} :
							{pend_q[5], pend_q[4], pend_q[3], pend_q[2]};
					end
				end
			end
		end else if (op[7:3] == x86pd_pkg::OP_MOV_LO[7:3]) begin
			want = mode_q[1] ? 4'd9 : 4'd5;
			if (cnt_q < want) begin
				if (!end_q) wait_more = 1'b1;
				else rec.inst_class = x86pd_pkg::CL_DBTRUNC;
			end else begin
				rec.inst_class = x86pd_pkg::CL_MOV;
				rec.inst_length = want;
				rec.reg_index = op[2:0];
				rec.imm_value = mode_q[1] ?
					{pend_q[8], pend_q[7], pend_q[6], pend_q[5],
					 pend_q[4], pend_q[3], pend_q[2], pend_q[1]} :
					{32'd0, pend_q[4], pend_q[3], pend_q[2], pend_q[1]};
			end
		end else begin
			if (op == x86pd_pkg::OP_RETIMM) begin
				want = 4'd3;
				c_cls = x86pd_pkg::CL_RETIMM;
			end else if (op == x86pd_pkg::OP_CALL) begin
				want = 4'd5;
				c_cls = x86pd_pkg::CL_CALLREL;
			end else if (op == x86pd_pkg::OP_JMP32) begin
				want = 4'd5;
				c_cls = x86pd_pkg::CL_JMP32;
			end else if (op == x86pd_pkg::OP_JMP8) begin
				want = 4'd2;
				c_cls = x86pd_pkg::CL_JMP8;
				rel8 = 1'b1;
			end else if (op[7:4] == x86pd_pkg::OP_JCC_LO[7:4]) begin
				want = 4'd2;
				c_cls = x86pd_pkg::CL_JCC8;
				rel8 = 1'b1;
			end else if (op == x86pd_pkg::OP_ESC) begin
				if (cnt_q < 4'd2) begin
					if (!end_q) wait_more = 1'b1;
				end else if (m[7:4] == 4'h8) begin
					want = 4'd6;
					c_cls = x86pd_pkg::CL_JCC32;
					relpos2 = 1'b1;
				end
			end
			if (want != 4'd0) begin
				if (cnt_q < want) begin
					if (!end_q) wait_more = 1'b1;
				end else begin
					rec.inst_class = c_cls;
					rec.inst_length = want;
					if (c_cls == x86pd_pkg::CL_RETIMM) begin
						rec.imm_value = {48'd0, pend_q[2], pend_q[1]};
					end else begin
						if (rel8) rel = 32'(signed'(pend_q[1]));
						else if (relpos2) rel = {pend_q[5], pend_q[4], pend_q[3], pend_q[2]};
						else rel = {pend_q[4], pend_q[3], pend_q[2], pend_q[1]};
						rec.branch_target = (addr_q + 32'(want) + rel) & x86pd_pkg::ADDR_MASK;
					end
				end
			end
		end
		if (rec.inst_class == x86pd_pkg::CL_DBUNK) rec.imm_value = {56'd0, op};
		rec.last_of_run = end_q && (cnt_q == rec.inst_length);
	end

	assign stat.can_emit = (cnt_q != 4'd0) && !wait_more;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= x86pd_pkg::MODE_X86_32;
			start_q <= '0;
			cnt_q <= '0;
			addr_q <= '0;
			in_region_q <= 1'b0;
			end_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == x86pd_pkg::CFG_ARCH_MODE) mode_q <= cfg_data[1:0];
				else start_q <= cfg_data;
			end
			if (cmd.append) begin
				end_q <= in_item.region_end;
				if (!in_region_q) addr_q <= start_q & x86pd_pkg::ADDR_MASK;
				in_region_q <= 1'b1;
				cnt_q <= cnt_q + 4'd1;
			end else if (cmd.emit) begin
				addr_q <= (addr_q + 32'(rec.inst_length)) & x86pd_pkg::ADDR_MASK;
				cnt_q <= cnt_q - rec.inst_length;
				if (rec.last_of_run) in_region_q <= 1'b0;
			end
		end
	end

	// byte queue: append at the tail, drop the head instruction on emit
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			for (int i = 0; i < x86pd_pkg::MAXPEND; i++) begin
				if (cnt_q == 4'(i)) pend_q[i] <= in_item.code_byte;
			end
		end else if (cmd.emit) begin
			for (int i = 0; i < x86pd_pkg::MAXPEND; i++) begin
				if (5'(i) + 5'(rec.inst_length) < 5'(x86pd_pkg::MAXPEND))
					pend_q[i] <= pend_q[4'(5'(i) + 5'(rec.inst_length))];
			end
		end
		if (cmd.emit) out_q <= rec;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(x86pd_pkg::MAXPEND)) else $error("byte queue overflow");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && rec.last_of_run) |=> (cnt_q == 4'd0 && !in_region_q))
		else $error("region not flushed after last record");

endmodule

FILE: bench/tb.sv
module tb;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE = 24;
	localparam int N_ITEMS = 380;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	x86pd_pkg::in_item_t  in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	x86pd_pkg::out_item_t out_item;

	x86_subset_instruction_predecoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// predictor state
	logic [7:0]  held_bytes [x86pd_pkg::MAXPEND];
	int          held_cnt = 0;
	logic [31:0] pc_addr = '0;
	bit          region_open = 0;
	logic [1:0]  mode_reg = x86pd_pkg::MODE_X86_32;
	logic [31:0] base_addr = '0;

	x86pd_pkg::out_item_t record_q [$];
	int          errors = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	bit          gaps_on = 1;
	bit          rx_stalls = 1;
	bit          hold_go = 0;
	int          hold_len = 0;
	int          idle_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] le_bytes(int pos, int n);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < n; k++)
			v[8*k +: 8] = held_bytes[(pos + k) % x86pd_pkg::MAXPEND];
		return v;
	endfunction

	// returns bytes consumed by the head instruction, 0 when more are needed
	function automatic int decode_head(input bit at_end, output x86pd_pkg::out_item_t r);
		int avail, len, need, dpos, dw, want, relpos, relw;
		logic [7:0] op, m;
		logic [3:0] cls, c;
		logic [1:0] md;
		logic [2:0] rm, rg;
		logic [31:0] rel;
		r = '0;
		r.inst_address = pc_addr;
		avail = held_cnt;
		op = held_bytes[0];
		len = 1;
		cls = x86pd_pkg::CL_DBUNK;
		if (mode_reg == x86pd_pkg::MODE_NONX86) begin
			cls = x86pd_pkg::CL_DBUNK;
		end else if (op == x86pd_pkg::OP_NOP) begin
			cls = x86pd_pkg::CL_NOP;
		end else if (op >= x86pd_pkg::OP_PUSH_LO && op <= x86pd_pkg::OP_POP_HI) begin
			cls = (op < x86pd_pkg::OP_PUSH_LO + 8'd8) ? x86pd_pkg::CL_PUSH : x86pd_pkg::CL_POP;
			r.reg_index = op[2:0];
		end else if (op == x86pd_pkg::OP_RET) begin
			cls = x86pd_pkg::CL_RET;
		end else if (op == x86pd_pkg::OP_GRP5) begin
			if (avail < 2) begin
				if (!at_end) return 0;
			end else begin
				m = held_bytes[1];
				md = m[7:6];
				rm = m[2:0];
				rg = m[5:3];
				dpos = 0;
				dw = 0;
				if (md == 2'd3) begin
					need = 2;
				end else if (rm == 3'd4) begin
					if (avail < 3) begin
						need = 3;
					end else begin
						if (md == 2'd0 && held_bytes[2][2:0] == 3'd5) dw = 4;
						else if (md == 2'd1) dw = 1;
						else if (md == 2'd2) dw = 4;
						dpos = 3;
						need = 3 + dw;
					end
				end else begin
					if (md == 2'd0 && rm == 3'd5) dw = 4;
					else if (md == 2'd1) dw = 1;
					else if (md == 2'd2) dw = 4;
					dpos = 2;
					need = 2 + dw;
				end
				if (avail < need) begin
					if (!at_end) return 0;
					cls = x86pd_pkg::CL_DBTRUNC;
				end else begin
					cls = (rg == 3'd2) ? x86pd_pkg::CL_CALLIND :
						((rg == 3'd4) ? x86pd_pkg::CL_JMPIND : x86pd_pkg::CL_FFOTHER);
					len = need;
					r.operand_is_memory = (md != 2'd3);
					r.modrm_value = m;
					if (md != 2'd3 && rm == 3'd4) r.sib_value = held_bytes[2];
					if (dw == 1) r.displacement = {{24{held_bytes[dpos][7]}}, held_bytes[dpos]};
					else if (dw == 4) r.displacement = 32'(le_bytes(dpos, 4));
				end
			end
		end else if (op >= x86pd_pkg::OP_MOV_LO && op <= x86pd_pkg::OP_MOV_LO + 8'd7) begin
			want = mode_reg[1] ? 9 : 5;
			if (avail < want) begin
				if (!at_end) return 0;
				cls = x86pd_pkg::CL_DBTRUNC;
			end else begin
				cls = x86pd_pkg::CL_MOV;
				len = want;
				r.reg_index = op[2:0];
				r.imm_value = le_bytes(1, want - 1);
			end
		end else begin
			want = 0;
			c = x86pd_pkg::CL_DBUNK;
			relpos = 0;
			relw = 0;
			if (op == x86pd_pkg::OP_RETIMM) begin
				want = 3; c = x86pd_pkg::CL_RETIMM;
			end else if (op == x86pd_pkg::OP_CALL) begin
				want = 5; c = x86pd_pkg::CL_CALLREL; relpos = 1; relw = 4;
			end else if (op == x86pd_pkg::OP_JMP32) begin
				want = 5; c = x86pd_pkg::CL_JMP32; relpos = 1; relw = 4;
			end else if (op == x86pd_pkg::OP_JMP8) begin
				want = 2; c = x86pd_pkg::CL_JMP8; relpos = 1; relw = 1;
			end else if (op >= x86pd_pkg::OP_JCC_LO && op <= x86pd_pkg::OP_JCC_LO + 8'd15) begin
				want = 2; c = x86pd_pkg::CL_JCC8; relpos = 1; relw = 1;
			end else if (op == x86pd_pkg::OP_ESC) begin
				if (avail < 2) begin
					if (!at_end) return 0;
				end else if (held_bytes[1][7:4] == 4'h8) begin
					want = 6; c = x86pd_pkg::CL_JCC32; relpos = 2; relw = 4;
				end
			end
			if (want > 0) begin
				if (avail < want) begin
					if (!at_end) return 0;
				end else begin
					cls = c;
					len = want;
					if (c == x86pd_pkg::CL_RETIMM) begin
						r.imm_value = le_bytes(1, 2);
					end else begin
						rel = (relw == 1) ? {{24{held_bytes[relpos][7]}}, held_bytes[relpos]}
							: 32'(le_bytes(relpos, 4));
						r.branch_target = (pc_addr + 32'(len) + rel) & x86pd_pkg::ADDR_MASK;
					end
				end
			end
		end
		if (cls == x86pd_pkg::CL_DBUNK) r.imm_value = {56'd0, op};
		r.inst_length = 4'(len);
		r.inst_class = cls;
		return len;
	endfunction

	function automatic void predict_byte(logic [7:0] b, bit at_end);
		x86pd_pkg::out_item_t r;
		int len, k;
		k = 0;
		if (!region_open) begin
			pc_addr = base_addr & x86pd_pkg::ADDR_MASK;
			region_open = 1;
		end
		if (held_cnt < x86pd_pkg::MAXPEND) begin
			held_bytes[held_cnt] = b;
			held_cnt++;
		end
		while (held_cnt > 0 && k < x86pd_pkg::MAXPEND) begin
			len = decode_head(at_end, r);
			if (len == 0 || len > held_cnt) break;
			record_q = {record_q, r};
			for (int j = 0; j < held_cnt - len; j++)
				held_bytes[j] = held_bytes[j + len];
			held_cnt -= len;
			pc_addr = (pc_addr + 32'(len)) & x86pd_pkg::ADDR_MASK;
			k++;
		end
		if (at_end) begin
			if (k > 0) record_q[$].last_of_run = 1'b1;
			held_cnt = 0;
			region_open = 0;
		end
	endfunction

	task automatic send_byte(logic [7:0] b, bit at_end);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_item <= '{code_byte: b, region_end: at_end};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_byte(b, at_end);
		bytes_sent++;
	endtask

	task automatic send_bytes(logic [7:0] q[$]);
		foreach (q[i]) send_byte(q[i], i == q.size() - 1);
	endtask

	// wait until every record has come out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (record_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == x86pd_pkg::CFG_ARCH_MODE) mode_reg = val[1:0];
		else base_addr = val;
	endtask

	// one well-formed instruction with random content, or an odd byte now and then
	function automatic void add_instr(ref logic [7:0] q[$], input bit wide);
		logic [7:0] m, s;
		int dw;
		case ($urandom_range(0, 13))
			0: q = {q, x86pd_pkg::OP_NOP};
			1: q = {q, 8'($urandom_range(x86pd_pkg::OP_PUSH_LO, x86pd_pkg::OP_POP_HI))};
			2: q = {q, x86pd_pkg::OP_RET};
			3: begin
				q = {q, x86pd_pkg::OP_RETIMM};
				repeat (2) q = {q, 8'($urandom)};
			end
			4, 5: begin
				q = {q, ($urandom_range(0, 1) ? x86pd_pkg::OP_CALL : x86pd_pkg::OP_JMP32)};
				repeat (4) q = {q, 8'($urandom)};
			end
			6: begin
				q = {q, x86pd_pkg::OP_JMP8};
				q = {q, 8'($urandom)};
			end
			7: begin
				q = {q, 8'($urandom_range(x86pd_pkg::OP_JCC_LO, x86pd_pkg::OP_JCC_LO + 15))};
				q = {q, 8'($urandom)};
			end
			8: begin
				q = {q, x86pd_pkg::OP_ESC};
				q = {q, 8'($urandom_range(8'h80, 8'h8f))};
				repeat (4) q = {q, 8'($urandom)};
			end
			9, 10: begin
				m = 8'($urandom);
				q = {q, x86pd_pkg::OP_GRP5};
				q = {q, m};
				dw = 0;
				if (m[7:6] != 2'd3 && m[2:0] == 3'd4) begin
					s = 8'($urandom);
					q = {q, s};
					if (m[7:6] == 2'd0 && s[2:0] == 3'd5) dw = 4;
				end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
					dw = 4;
				end
				if (m[7:6] == 2'd1) dw = 1;
				if (m[7:6] == 2'd2) dw = 4;
				repeat (dw) q = {q, 8'($urandom)};
			end
			11: begin
				q = {q, 8'($urandom_range(x86pd_pkg::OP_MOV_LO, x86pd_pkg::OP_MOV_LO + 7))};
				repeat (wide ? 8 : 4) q = {q, 8'($urandom)};
			end
			12: begin
				q = {q, x86pd_pkg::OP_ESC};
				q = {q, 8'($urandom_range(0, 1) ? $urandom_range(0, 8'h7f)
					: $urandom_range(8'h90, 8'hff))};
			end
			default: q = {q, 8'($urandom)};
		endcase
	endfunction

	task automatic send_region(int n_instr, bit chop);
		logic [7:0] q[$];
		int cut;
		for (int i = 0; i < n_instr; i++) add_instr(q, mode_reg[1]);
		if (chop && q.size() > 1) begin
			cut = $urandom_range(1, q.size() - 1 < 8 ? q.size() - 1 : 8);
			repeat (cut) void'(q.pop_back());
		end
		send_bytes(q);
	endtask

	task automatic chk(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// record checker
	always @(posedge clk) begin
		x86pd_pkg::out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (record_q.size() == 0) begin
				$display("%0t unexpected record: expected none actual %h", $time, out_item);
				errors++;
			end else begin
				e = record_q.pop_front();
				chk("inst_address", e.inst_address, out_item.inst_address);
				chk("inst_length", e.inst_length, out_item.inst_length);
				chk("inst_class", e.inst_class, out_item.inst_class);
				chk("reg_index", e.reg_index, out_item.reg_index);
				chk("operand_is_memory", e.operand_is_memory, out_item.operand_is_memory);
				chk("modrm_value", e.modrm_value, out_item.modrm_value);
				chk("sib_value", e.sib_value, out_item.sib_value);
				chk("displacement", e.displacement, out_item.displacement);
				chk("branch_target", e.branch_target, out_item.branch_target);
				chk("imm_value", e.imm_value, out_item.imm_value);
				chk("last_of_run", e.last_of_run, out_item.last_of_run);
			end
		end
	end

	// receiver: long hold-off on request, else random stalls with a periodic ready window, or always ready
	always @(posedge clk) begin
		int ph;
		if (hold_go) begin
			hold_go <= 1'b0;
			hold_len <= 400;
			out_ready <= 1'b0;
		end else if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			out_ready <= 1'b0;
		end else if (rx_stalls) begin
			ph = $urandom_range(0, 9);
			out_ready <= (ph < 6) || ($time % 22 < 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT) begin
				$display("** x86_subset_instruction_predecoder: FAILED **");
				$finish;
			end
		end
	end

	task automatic test_x86_32();
		logic [7:0] q[$];
		write_reg(x86pd_pkg::CFG_ARCH_MODE, 32'(x86pd_pkg::MODE_X86_32));
		write_reg(x86pd_pkg::CFG_START_ADDRESS, 32'h0000_1000);
		q = '{x86pd_pkg::OP_NOP, 8'h50, x86pd_pkg::OP_POP_HI, x86pd_pkg::OP_RET,
			x86pd_pkg::OP_RETIMM, 8'h34, 8'h12,
			x86pd_pkg::OP_CALL, 8'h10, 8'h00, 8'h00, 8'h00, x86pd_pkg::OP_JMP8, 8'h80,
			8'h7f, 8'h7f,
			x86pd_pkg::OP_ESC, 8'h85, 8'hf0, 8'hff, 8'hff, 8'hff, x86pd_pkg::OP_ESC, 8'h00,
			x86pd_pkg::OP_GRP5, 8'h15, 8'h78, 8'h56, 8'h34, 8'h12, x86pd_pkg::OP_GRP5, 8'he0,
			x86pd_pkg::OP_GRP5, 8'h44, 8'h24, 8'hf8, x86pd_pkg::OP_GRP5, 8'h14, 8'h25, 8'h01,
			8'h02, 8'h03, 8'h04,
			x86pd_pkg::OP_GRP5, 8'hb0, 8'h00, 8'h00, 8'h00, 8'h80, x86pd_pkg::OP_GRP5, 8'h30,
			8'hbf, 8'hef, 8'hbe, 8'had, 8'hde, 8'h00, 8'hff,
			x86pd_pkg::OP_JMP32, 8'h00, 8'h00, 8'h00, 8'h80, x86pd_pkg::OP_CALL, 8'h11, 8'h22};
		send_bytes(q);
		// truncated heads at region end
		send_bytes('{x86pd_pkg::OP_GRP5});
		send_bytes('{x86pd_pkg::OP_GRP5, 8'h15, 8'h00});
		send_bytes('{x86pd_pkg::OP_GRP5, 8'h04});
		send_bytes('{8'hb8, 8'h01, 8'h02});
		send_bytes('{x86pd_pkg::OP_ESC});
		send_bytes('{x86pd_pkg::OP_RETIMM, x86pd_pkg::OP_NOP});
	endtask

	task automatic test_x86_64_wrap();
		write_reg(x86pd_pkg::CFG_ARCH_MODE, 32'(x86pd_pkg::MODE_X86_64));
		write_reg(x86pd_pkg::CFG_START_ADDRESS, 32'hffff_fffc);
		send_bytes('{x86pd_pkg::OP_JMP32, 8'h00, 8'h00, 8'h00, 8'h00, 8'hb9, 8'h11, 8'h22,
			8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, x86pd_pkg::OP_JMP8, 8'hfe, 8'hba, 8'h01});
		write_reg(x86pd_pkg::CFG_ARCH_MODE, 32'd3);
		send_bytes('{8'hbb, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
	endtask

	task automatic test_non_x86();
		write_reg(x86pd_pkg::CFG_ARCH_MODE, 32'(x86pd_pkg::MODE_NONX86));
		write_reg(x86pd_pkg::CFG_START_ADDRESS, 32'h0);
		send_bytes('{x86pd_pkg::OP_NOP, x86pd_pkg::OP_GRP5, x86pd_pkg::OP_CALL, 8'hb8,
			8'h00, 8'hff});
	endtask

	task automatic test_backpressure();
		write_reg(x86pd_pkg::CFG_ARCH_MODE, 32'(x86pd_pkg::MODE_X86_32));
		gaps_on = 0;
		hold_go = 1;
		repeat (3) send_region(6, 0);
		gaps_on = 1;
		drain();
		rx_stalls = 0;
		repeat (2) send_region(5, 0);
		rx_stalls = 1;
	endtask

	task automatic test_random();
		while (bytes_sent < N_ITEMS) begin
			write_reg(x86pd_pkg::CFG_ARCH_MODE,
				32'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3)));
			case ($urandom_range(0, 3))
				0: write_reg(x86pd_pkg::CFG_START_ADDRESS, 32'hffff_fff0 + $urandom_range(0, 15));
				1: write_reg(x86pd_pkg::CFG_START_ADDRESS, 32'($urandom_range(0, 15)));
				default: write_reg(x86pd_pkg::CFG_START_ADDRESS, $urandom);
			endcase
			repeat ($urandom_range(1, 4))
				send_region($urandom_range(1, 10), $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_x86_32();
		test_x86_64_wrap();
		test_non_x86();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0 && record_q.size() == 0) begin
			$display("** x86_subset_instruction_predecoder: PASSED **");
		end else begin
			$display("** x86_subset_instruction_predecoder: FAILED **");
		end
		$finish;
	end

endmodule
